// ===== hdl/btop_pkg.sv =====
// ----------------------------------------------------------------------------
// btop_pkg
// shared types, constants and fixed-point helpers of the binomial tree pricer
// ----------------------------------------------------------------------------
package btop_pkg;

	localparam int unsigned MAX_STEPS_DEF = 512;

	localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic [2:0] REG_UP_FACTOR     = 3'd0;
	localparam logic [2:0] REG_DOWN_FACTOR   = 3'd1;
	localparam logic [2:0] REG_PROB_UP       = 3'd2;
	localparam logic [2:0] REG_STEP_DISCOUNT = 3'd3;
	localparam logic [2:0] REG_TREE_STEPS    = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_UP,
		OP_LEAF_A,
		OP_LEAF_B,
		OP_PAY,
		OP_RB0,
		OP_RB1,
		OP_RB2,
		OP_RB3,
		OP_RB4
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP,
		ST_LEAF_A,
		ST_LEAF_B,
		ST_PAY,
		ST_RB0,
		ST_RB1,
		ST_RB2,
		ST_RB3,
		ST_RB4,
		ST_DONE
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		op_t         op;
		logic [31:0] spot;
		logic [31:0] strike;
		logic        is_call;
		logic        american;
		logic [31:0] fu;
		logic [31:0] fd;
		logic [31:0] fp;
		logic [31:0] fq;
		logic [31:0] fdisc;
	} cell_ctrl_t;

	// (price * factor) >> 30, saturated
	function automatic logic [31:0] scale(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		prod = 64'(a) * 64'(b);
		if (prod[63:62] != 2'b00)
			return PRICE_MAX;
		return prod[61:30];
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = 33'(a) + 33'(b);
		return s[32] ? PRICE_MAX : s[31:0];
	endfunction

	function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
		input logic call);
		if (call)
			return (s > k) ? s - k : 32'd0;
		return (k > s) ? k - s : 32'd0;
	endfunction

endpackage

// ===== hdl/binomial_tree_option_pricer_top.sv =====
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top
// cox-ross-rubinstein option pricer over a row of node cells
// ----------------------------------------------------------------------------
// one request word (spot, strike, call/put, american/european) gives one
// price word, unsigned q16.16. the tree has MAX_STEPS+1 cells in a row, each
// with one 32x32 multiplier; cell i is tree node i. a request runs in this
// order for N tree steps: spot*u in the first cell once per step, the
// leaf spot wave (two d multiplies per pass along the row, N passes), one
// payoff step, then per rollback level the five uses of each cell's
// multiplier-and-compare. one request is in work at a time;
// a finished price sits in the output register while the next request starts.
// configuration words may only be written while the block is idle.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer_top #(
	parameter int unsigned MAX_STEPS = btop_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] spot,
	input  logic [31:0] strike,
	input  logic        is_call,
	input  logic        american,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] price,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned NW = $clog2(MAX_STEPS + 1);
	localparam int unsigned CW = (NW > 10) ? NW : 10;

	// configuration registers
	logic [31:0] up_factor_q;
	logic [30:0] down_factor_q;
	logic [30:0] prob_up_q;
	logic [30:0] step_discount_q;
	logic [9:0]  tree_steps_q;

	// request registers
	logic [31:0] strike_q;
	logic        call_q;
	logic        amer_q;

	btop_pkg::state_t state_q, state_d;
	btop_pkg::op_t    op;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    n_eff;
	logic [CW-1:0]    steps_ext;
	logic [31:0]      p_eff;
	logic             in_acc;
	logic             out_load;
	logic             out_valid_q;
	logic [31:0]      price_q;

	btop_pkg::cell_ctrl_t ctrl;
	logic [31:0] spot_w [0:MAX_STEPS];
	logic [31:0] val_w  [0:MAX_STEPS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_factor_q     <= btop_pkg::ONE_Q30;
			down_factor_q   <= 31'(btop_pkg::ONE_Q30);
			prob_up_q       <= 31'h2000_0000;
			step_discount_q <= 31'(btop_pkg::ONE_Q30);
			tree_steps_q    <= 10'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				btop_pkg::REG_UP_FACTOR:     up_factor_q     <= cfg_data;
				btop_pkg::REG_DOWN_FACTOR:   down_factor_q   <= cfg_data[30:0];
				btop_pkg::REG_PROB_UP:       prob_up_q       <= cfg_data[30:0];
				btop_pkg::REG_STEP_DISCOUNT: step_discount_q <= cfg_data[30:0];
				btop_pkg::REG_TREE_STEPS:    tree_steps_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// step count: zero acts as one, above MAX_STEPS saturates to MAX_STEPS
	assign steps_ext = CW'(tree_steps_q);
	always_comb begin
		if (steps_ext == '0)
			n_eff = CW'(1);
		else if (steps_ext > CW'(MAX_STEPS))
			n_eff = CW'(MAX_STEPS);
		else
			n_eff = steps_ext;
	end

	// up probability clamped to one, down probability is its complement
	assign p_eff = (32'(prob_up_q) > btop_pkg::ONE_Q30) ? btop_pkg::ONE_Q30 : 32'(prob_up_q);

	assign in_stall = (state_q != btop_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == btop_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// sequencer: next state and the op broadcast to the row
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		op      = btop_pkg::OP_NONE;
		case (state_q)
			btop_pkg::ST_IDLE: begin
				if (in_acc) begin
					op      = btop_pkg::OP_LOAD;
					state_d = btop_pkg::ST_UP;
					cnt_d   = n_eff - CW'(1);
				end
			end
			btop_pkg::ST_UP: begin
				op = btop_pkg::OP_UP;
				if (cnt_q == '0) begin
					state_d = btop_pkg::ST_LEAF_A;
					cnt_d   = n_eff - CW'(1);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			btop_pkg::ST_LEAF_A: begin
				op      = btop_pkg::OP_LEAF_A;
				state_d = btop_pkg::ST_LEAF_B;
			end
			btop_pkg::ST_LEAF_B: begin
				op = btop_pkg::OP_LEAF_B;
				if (cnt_q == '0) begin
					state_d = btop_pkg::ST_PAY;
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = btop_pkg::ST_LEAF_A;
				end
			end
			btop_pkg::ST_PAY: begin
				op      = btop_pkg::OP_PAY;
				state_d = btop_pkg::ST_RB0;
				cnt_d   = n_eff - CW'(1);
			end
			btop_pkg::ST_RB0: begin
				op      = btop_pkg::OP_RB0;
				state_d = btop_pkg::ST_RB1;
			end
			btop_pkg::ST_RB1: begin
				op      = btop_pkg::OP_RB1;
				state_d = btop_pkg::ST_RB2;
			end
			btop_pkg::ST_RB2: begin
				op      = btop_pkg::OP_RB2;
				state_d = btop_pkg::ST_RB3;
			end
			btop_pkg::ST_RB3: begin
				op      = btop_pkg::OP_RB3;
				state_d = btop_pkg::ST_RB4;
			end
			btop_pkg::ST_RB4: begin
				op = btop_pkg::OP_RB4;
				if (cnt_q == '0) begin
					state_d = btop_pkg::ST_DONE;
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = btop_pkg::ST_RB0;
				end
			end
			btop_pkg::ST_DONE: begin
				if (out_load)
					state_d = btop_pkg::ST_IDLE;
			end
			default: state_d = btop_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btop_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		if (in_acc) begin
			strike_q <= strike;
			call_q   <= is_call;
			amer_q   <= american;
		end
		if (out_load)
			price_q <= val_w[0];
	end

	assign out_valid = out_valid_q;
	assign price     = price_q;

	always_comb begin
		ctrl.op       = op;
		ctrl.spot     = spot;
		ctrl.strike   = strike_q;
		ctrl.is_call  = call_q;
		ctrl.american = amer_q;
		ctrl.fu       = up_factor_q;
		ctrl.fd       = 32'(down_factor_q);
		ctrl.fp       = p_eff;
		ctrl.fq       = btop_pkg::ONE_Q30 - p_eff;
		ctrl.fdisc    = 32'(step_discount_q);
	end

	// row of node cells; the last cell sees a zero right neighbor
	assign val_w[MAX_STEPS+1] = '0;

	genvar g;
	generate
		for (g = 0; g <= MAX_STEPS; g++) begin : g_cell
			btop_cell #(
				.IS_FIRST (g == 0)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.left_spot   (spot_w[(g == 0) ? 0 : g - 1]),
				.right_value (val_w[g + 1]),
				.spot_out    (spot_w[g]),
				.value_out   (val_w[g])
			);
		end
	endgenerate

endmodule

// ===== hdl/btop_cell.sv =====
// ----------------------------------------------------------------------------
// btop_cell
// one tree node: holds a node spot and a node value, one shared multiplier
// ----------------------------------------------------------------------------
module btop_cell #(
	parameter bit IS_FIRST = 1'b0
) (
	input  logic                  clk,
	input  btop_pkg::cell_ctrl_t  ctrl,
	input  logic [31:0]           left_spot,
	input  logic [31:0]           right_value,
	output logic [31:0]           spot_out,
	output logic [31:0]           value_out
);

	logic [31:0] spot_q;
	logic [31:0] value_q;
	logic [31:0] ta_q;
	logic [31:0] tb_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] exer;

	always_comb begin
		case (ctrl.op)
			btop_pkg::OP_UP: begin
				mul_a = spot_q;
				mul_b = ctrl.fu;
			end
			btop_pkg::OP_LEAF_A: begin
				mul_a = left_spot;
				mul_b = ctrl.fd;
			end
			btop_pkg::OP_LEAF_B: begin
				mul_a = ta_q;
				mul_b = ctrl.fd;
			end
			btop_pkg::OP_RB0: begin
				mul_a = value_q;
				mul_b = ctrl.fp;
			end
			btop_pkg::OP_RB1: begin
				mul_a = right_value;
				mul_b = ctrl.fq;
			end
			btop_pkg::OP_RB2: begin
				mul_a = btop_pkg::sat_add(ta_q, tb_q);
				mul_b = ctrl.fdisc;
			end
			btop_pkg::OP_RB3: begin
				mul_a = spot_q;
				mul_b = ctrl.fd;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = btop_pkg::scale(mul_a, mul_b);
	assign exer = btop_pkg::payoff(spot_q, ctrl.strike, ctrl.is_call);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			btop_pkg::OP_LOAD: begin
				if (IS_FIRST)
					spot_q <= ctrl.spot;
			end
			btop_pkg::OP_UP: begin
				if (IS_FIRST)
					spot_q <= prod;
			end
			btop_pkg::OP_LEAF_A: begin
				if (!IS_FIRST)
					ta_q <= prod;
			end
			btop_pkg::OP_LEAF_B: begin
				if (!IS_FIRST)
					spot_q <= prod;
			end
			btop_pkg::OP_PAY: value_q <= exer;
			btop_pkg::OP_RB0: ta_q <= prod;
			btop_pkg::OP_RB1: tb_q <= prod;
			btop_pkg::OP_RB2: ta_q <= prod;
			btop_pkg::OP_RB3: spot_q <= prod;
			btop_pkg::OP_RB4: value_q <= (ctrl.american && exer > ta_q) ? exer : ta_q;
			default: ;
		endcase
	end

	assign spot_out  = spot_q;
	assign value_out = value_q;

endmodule

// ===== tb/binomial_tree_option_pricer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top_test
// self-checking bench for the cox-ross-rubinstein option pricer
// ----------------------------------------------------------------------------
// requests go through a valid/stall channel with random gaps and the price
// channel is stalled at random. a scoreboard class keeps its own copy of the
// tree registers, rolls the tree back in plain arithmetic for every accepted
// request and compares each returned price with the oldest expected one.
// tree settings change between phases, only once the block has gone idle.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer_top_test;

	localparam int          TREE_CAP      = int'(btop_pkg::MAX_STEPS_DEF);
	localparam int          ITEM_GOAL     = 290;
	localparam int          WATCHDOG_MAX  = 60000;
	localparam logic [2:0]  REG_SPARE_LO  = 3'd5;
	localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

	// ------------------------------------------------------------------
	// scoreboard: predicted prices in arrival order
	// ------------------------------------------------------------------
	class price_board;
		logic [31:0] u_fac, d_fac, p_up, disc;
		logic [9:0]  n_steps;
		logic [31:0] due_prices[$];
		logic [31:0] leaf_val[TREE_CAP + 1];
		logic [31:0] node_spot[TREE_CAP + 1];
		int          n_errors;

		function new();
			u_fac    = btop_pkg::ONE_Q30;
			d_fac    = btop_pkg::ONE_Q30;
			p_up     = 32'h2000_0000;
			disc     = btop_pkg::ONE_Q30;
			n_steps  = 10'd64;
			n_errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				btop_pkg::REG_UP_FACTOR:     u_fac   = data;
				btop_pkg::REG_DOWN_FACTOR:   d_fac   = {1'b0, data[30:0]};
				btop_pkg::REG_PROB_UP:       p_up    = {1'b0, data[30:0]};
				btop_pkg::REG_STEP_DISCOUNT: disc    = {1'b0, data[30:0]};
				btop_pkg::REG_TREE_STEPS:    n_steps = data[9:0];
				default: ;
			endcase
		endfunction

		// depth actually used by the tree
		function int depth();
			if (n_steps == 0)
				return 1;
			if (n_steps > TREE_CAP)
				return TREE_CAP;
			return int'(n_steps);
		endfunction

		function logic [31:0] mul_q30(logic [31:0] a, logic [31:0] b);
			logic [63:0] prod;
			prod = ({32'b0, a} * {32'b0, b}) >> 30;
			return (prod[63:32] != 0) ? 32'hFFFF_FFFF : prod[31:0];
		endfunction

		function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function logic [31:0] exercise(logic [31:0] s, logic [31:0] k, logic call);
			if (call)
				return (s > k) ? s - k : 32'd0;
			return (k > s) ? k - s : 32'd0;
		endfunction

		function void note_request(logic [31:0] s, logic [31:0] k, logic call,
			logic amer);
			int          n;
			logic [31:0] pp, qq, hold, ex, x;
			n  = depth();
			pp = (p_up > btop_pkg::ONE_Q30) ? btop_pkg::ONE_Q30 : p_up;
			qq = btop_pkg::ONE_Q30 - pp;
			x  = s;
			for (int i = 0; i < n; i++)
				x = mul_q30(x, u_fac);
			node_spot[0] = x;
			for (int i = 1; i <= n; i++)
				node_spot[i] = mul_q30(mul_q30(node_spot[i - 1], d_fac), d_fac);
			for (int i = 0; i <= n; i++)
				leaf_val[i] = exercise(node_spot[i], k, call);
			for (int lvl = n - 1; lvl >= 0; lvl--) begin
				for (int i = 0; i <= lvl; i++) begin
					hold = mul_q30(add_sat(mul_q30(leaf_val[i], pp),
						mul_q30(leaf_val[i + 1], qq)), disc);
					node_spot[i] = mul_q30(node_spot[i], d_fac);
					if (amer) begin
						ex = exercise(node_spot[i], k, call);
						if (ex > hold)
							hold = ex;
					end
					leaf_val[i] = hold;
				end
			end
			due_prices.push_back(leaf_val[0]);
		endfunction

		function void check_price(logic [31:0] got);
			logic [31:0] want;
			if (due_prices.size() == 0) begin
				$error("price word 0x%08h arrived with none expected", got);
				n_errors++;
				return;
			end
			want = due_prices.pop_front();
			if (got !== want) begin
				$error("price: expected 0x%08h, actual 0x%08h", want, got);
				n_errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] spot = '0;
	logic [31:0] strike = '0;
	logic        is_call = 1'b0;
	logic        american = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] price;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	price_board board = new();
	int         items_sent = 0;
	int         quiet_cycles = 0;
	bit         no_gaps = 0;

	binomial_tree_option_pricer_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .spot(spot), .strike(strike),
		.is_call(is_call), .american(american),
		.out_valid(out_valid), .out_stall(out_stall), .price(price),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// monitor: values read here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(spot, strike, is_call, american);
			if (out_valid && !out_stall)
				board.check_price(price);
			// watchdog: nothing moved on any channel
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// price side: random stall before each word, none at all in burst phases
	initial begin
		int hold_off;
		@(posedge clk iff arst_n);
		forever begin
			hold_off = no_gaps ? 0 : $urandom_range(0, 6);
			if (hold_off > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	// valid stays high after the write; the caller drops it when done
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic set_tree(logic [31:0] u, logic [31:0] d, logic [31:0] p,
		logic [31:0] r, logic [31:0] n);
		write_reg(btop_pkg::REG_UP_FACTOR, u);
		write_reg(btop_pkg::REG_DOWN_FACTOR, d);
		write_reg(btop_pkg::REG_PROB_UP, p);
		write_reg(btop_pkg::REG_STEP_DISCOUNT, r);
		write_reg(btop_pkg::REG_TREE_STEPS, n);
		cfg_valid <= 1'b0;
	endtask

	// valid stays high after the accept; a gap before the next word or drain() drops it
	task automatic send_word(logic [31:0] s, logic [31:0] k, logic c, logic a);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		spot     <= s;
		strike   <= k;
		is_call  <= c;
		american <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// wait for every expected price, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.due_prices.size() != 0) @(posedge clk);
		repeat (8 * board.depth() + 16) @(posedge clk);
	endtask

	// spot/strike pair: full range, near the money, tiny values or a middle range
	task automatic send_random();
		logic [31:0] s, k;
		case ($urandom_range(0, 3))
			0: begin
				s = $urandom();
				k = $urandom();
			end
			1: begin
				s = $urandom_range(0, 32'h00FF_FFFF);
				k = s + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			end
			2: begin
				s = $urandom_range(0, 32'h0000_FFFF);
				k = $urandom_range(0, 32'h0000_FFFF);
			end
			default: begin
				s = $urandom_range(32'h0001_0000, 32'h0100_0000);
				k = $urandom_range(32'h0001_0000, 32'h0100_0000);
			end
		endcase
		send_word(s, k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] u, d;
		int          n, cnt;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, 64 steps: extremes of spot and strike, every flag pair
		send_word(32'h0, 32'h0, 1'b1, 1'b0);
		send_word(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1);
		send_word(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		send_word(32'h0064_0000, 32'h005A_0000, 1'b1, 1'b0);
		send_word(32'h0064_0000, 32'h006E_0000, 1'b0, 1'b1);
		drain();

		// saturating factors, p above one, step count zero treated as one
		set_tree(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		send_word(32'h0001_0000, 32'h0000_8000, 1'b1, 1'b1);
		send_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);
		send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);
		send_word(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0);
		drain();

		// spare indexes must be ignored; step count over the cap, d above one
		for (logic [3:0] idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++)
			write_reg(idx[2:0], $urandom());
		set_tree(btop_pkg::ONE_Q30, 32'hFFFF_FFFF, 32'h0, btop_pkg::ONE_Q30, 32'h3FF);
		send_word(32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1);
		drain();

		// full depth with a realistic tree
		set_tree(32'h4100_0000, 32'h3F03_F03F, 32'h2080_0000, 32'h3FFF_0000, 32'd512);
		send_word(32'h0064_0000, 32'h0064_0000, 1'b0, 1'b1);
		send_word(32'h0064_0000, 32'h0060_0000, 1'b1, 1'b0);
		drain();

		// single step, unit up factor, zero down, probability and discount factors
		set_tree(btop_pkg::ONE_Q30, 32'h0, 32'h0, 32'h0, 32'd1);
		send_word(32'h0010_0000, 32'h0008_0000, 1'b1, 1'b1);
		send_word(32'h0010_0000, 32'h0020_0000, 1'b0, 1'b0);
		drain();

		// random phases, mostly shallow trees with random content
		while (items_sent < ITEM_GOAL) begin
			u = btop_pkg::ONE_Q30 + $urandom_range(0, 32'h1000_0000);
			d = 32'((64'h1 << 60) / u);
			case ($urandom_range(0, 9))
				0: n = $urandom_range(100, 1023);
				1, 2: n = $urandom_range(17, 64);
				default: n = $urandom_range(0, 16);
			endcase
			if ($urandom_range(0, 4) == 0)
				set_tree($urandom(), $urandom(), $urandom(), $urandom(), n);
			else
				set_tree(u, d, $urandom_range(32'h1000_0000, 32'h3000_0000),
					$urandom_range(32'h3C00_0000, btop_pkg::ONE_Q30), n);
			no_gaps = ($urandom_range(0, 3) == 0);
			cnt = (board.depth() > 64) ? 2 : $urandom_range(8, 25);
			repeat (cnt) send_random();
			drain();
		end

		if (board.n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
